>>> rtl/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg: shared types and constants of the RGB 3x3 convolution core
// Frame limits, coefficient layout, register indexes and queue entry types.
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COEFF_BITS  = 8;
  localparam int DIM_BITS    = 11;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
  localparam int KROW_BITS   = 24;
  localparam int SHIFT_BITS  = 4;
  localparam int PIX_BITS    = 24;
  localparam int PROD_BITS   = COEFF_BITS + 9;
  localparam int SUM_BITS    = PROD_BITS + 4;
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4,
    REG_RESULT_SHIFT  = 3'd5
  } reg_idx_t;

  typedef logic [PIX_BITS-1:0] pix_t;

  // Window held as [column][row], column 0 is the left, row 0 the top
  typedef logic [2:0][2:0][PIX_BITS-1:0] win_t;

  // Effective configuration seen by the front and back parts
  typedef struct packed {
    logic [DIM_BITS-1:0]                width;
    logic [DIM_BITS-1:0]                height;
    logic [2:0][KROW_BITS-1:0]          kernel;
    logic [SHIFT_BITS-1:0]              shift;
  } cfg_t;

  // One classified item waiting for the filter
  typedef struct packed {
    win_t win;
    logic emit_a;
    logic emit_b;
    logic drain;
  } q_entry_t;

  // Coefficient k of a kernel row, sign-extended by the caller's use
  function automatic logic signed [COEFF_BITS-1:0] coeff(input logic [KROW_BITS-1:0] krow,
                                                         input int k);
    coeff = krow[k*COEFF_BITS +: COEFF_BITS];
  endfunction

endpackage

>>> rtl/rcc_front.sv
// ----------------------------------------------------------------------------
// rcc_front: position tracking, line buffers and window
// Accepts requests, keeps the raster position, reads and updates the two line
// buffers and shifts the window; items that produce results go to the queue.
// ----------------------------------------------------------------------------
module rcc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  rcc_pkg::cfg_t    cfg,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_drain,
  input  rcc_pkg::pix_t    in_pix,
  output logic             q_push,
  output rcc_pkg::q_entry_t q_data,
  input  logic             q_full
);
  import rcc_pkg::*;

  logic [COL_BITS-1:0] col_r, col_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt;
  logic [DIM_BITS-1:0] dc_r, dc_nxt;

  logic [COL_BITS-1:0] wm1, c, col_base, ix;
  logic [ROW_BITS-1:0] hm1, r, row_base;
  logic                accept, active, abandon, last_col;

  // Second stage registers
  logic                s2_valid_r, s2_drain_r, s2_row0_r, s2_first_r;
  logic                s2_emit_a_r, s2_emit_b_r;
  logic [COL_BITS-1:0] s2_ix_r;
  pix_t                s2_pix_r;
  pix_t                up_rd_r, mid_rd_r, byp_up_r, byp_mid_r;
  logic                byp_r;
  win_t                win_r, win_nxt;
  logic                s2_adv;
  pix_t                up, mid, wr_up;
  pix_t                col0, col1, col2;

  pix_t upper_mem  [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];

  // Handshake: the second stage frees up unless its item waits on a full queue.
  assign s2_adv    = s2_valid_r && (!(s2_emit_a_r || s2_emit_b_r) || !q_full);
  assign in_tready = !s2_valid_r || s2_adv;
  assign accept    = in_tvalid && in_tready;

  // Position of the request, clamped to the current frame size.
  assign wm1      = COL_BITS'(cfg.width - DIM_BITS'(1));
  assign hm1      = ROW_BITS'(cfg.height - DIM_BITS'(1));
  assign active   = !(in_drain && (dc_r == '0));
  assign abandon  = !in_drain && (dc_r != '0);
  assign col_base = abandon ? '0 : col_r;
  assign row_base = abandon ? '0 : row_r;
  assign c        = (col_base > wm1) ? wm1 : col_base;
  assign r        = (row_base > hm1) ? hm1 : row_base;
  assign last_col = (c == wm1);
  assign ix       = c;

  // Next raster position and drain count.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    dc_nxt  = dc_r;
    if (accept && active) begin
      if (in_drain) begin
        dc_nxt  = last_col ? '0 : dc_r - DIM_BITS'(1);
        col_nxt = (dc_nxt == '0) ? '0 : c + COL_BITS'(1);
      end else begin
        dc_nxt  = '0;
        row_nxt = row_base;
        if (last_col) begin
          col_nxt = '0;
          if (r == hm1) begin
            row_nxt = '0;
            dc_nxt  = cfg.width;
          end else begin
            row_nxt = r + ROW_BITS'(1);
          end
        end else begin
          col_nxt = c + COL_BITS'(1);
        end
      end
    end
  end

  // Line buffer data, with a bypass of the write made by the item ahead.
  assign up    = byp_r ? byp_up_r  : up_rd_r;
  assign mid   = byp_r ? byp_mid_r : mid_rd_r;
  assign wr_up = s2_row0_r ? s2_pix_r : mid;

  // Column entering the window.
  always_comb begin
    if (s2_drain_r) begin
      col0 = up;
      col1 = mid;
      col2 = mid;
    end else if (s2_row0_r) begin
      col0 = s2_pix_r;
      col1 = s2_pix_r;
      col2 = s2_pix_r;
    end else begin
      col0 = up;
      col1 = mid;
      col2 = s2_pix_r;
    end
  end

  // Window shift, or a fresh fill at the first column.
  always_comb begin
    if (s2_first_r) begin
      for (int k = 0; k < 3; k++) begin
        win_nxt[k] = {col2, col1, col0};
      end
    end else begin
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      win_nxt[2] = {col2, col1, col0};
    end
  end

  assign q_push        = s2_adv && (s2_emit_a_r || s2_emit_b_r);
  assign q_data.win    = win_nxt;
  assign q_data.emit_a = s2_emit_a_r;
  assign q_data.emit_b = s2_emit_b_r;
  assign q_data.drain  = s2_drain_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      dc_r       <= '0;
      s2_valid_r <= 1'b0;
      byp_r      <= 1'b0;
      win_r      <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      dc_r  <= dc_nxt;
      if (in_tready) begin
        s2_valid_r <= accept && active;
      end
      if (accept) begin
        byp_r <= s2_valid_r && !s2_drain_r && (s2_ix_r == ix);
      end
      if (s2_adv) begin
        win_r <= win_nxt;
      end
    end
  end

  // Second stage payload and line buffer reads.
  always_ff @(posedge clk) begin
    if (accept) begin
      s2_drain_r  <= in_drain;
      s2_row0_r   <= !in_drain && (r == '0);
      s2_first_r  <= (c == '0);
      s2_emit_a_r <= (in_drain || (r != '0)) && (c != '0);
      s2_emit_b_r <= (in_drain || (r != '0)) && last_col;
      s2_ix_r     <= ix;
      s2_pix_r    <= in_pix;
      up_rd_r     <= upper_mem[ix];
      mid_rd_r    <= middle_mem[ix];
      byp_up_r    <= wr_up;
      byp_mid_r   <= s2_pix_r;
    end
  end

  // Line buffer writes for pixel requests.
  always_ff @(posedge clk) begin
    if (s2_adv && !s2_drain_r) begin
      upper_mem[s2_ix_r]  <= wr_up;
      middle_mem[s2_ix_r] <= s2_pix_r;
    end
  end

endmodule

>>> rtl/rcc_queue.sv
// ----------------------------------------------------------------------------
// rcc_queue: short queue between the front and the filter
// Holds classified windows so that each side can stall on its own.
// ----------------------------------------------------------------------------
module rcc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rcc_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output rcc_pkg::q_entry_t head
);
  import rcc_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  q_entry_t            mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_BITS:0]   count_r;

  assign full      = (count_r == (PTR_BITS+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + PTR_BITS'(1);
      end
      count_r <= count_r + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/rcc_back.sv
// ----------------------------------------------------------------------------
// rcc_back: kernel filter and output register
// Takes windows from the queue, forms one or two results for each, multiplies
// in one stage and sums, shifts and clips in the next.
// ----------------------------------------------------------------------------
module rcc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rcc_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  rcc_pkg::q_entry_t head,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output rcc_pkg::pix_t     out_pix,
  output logic              out_eol,
  output logic              out_eof,
  output logic              out_last
);
  import rcc_pkg::*;

  logic phase_r, phase_nxt;
  logic p_valid_r, o_valid_r;
  logic p_ready, o_ready, take, is_a, last;
  logic p_eol_r, p_eof_r, p_last_r;
  logic signed [PROD_BITS-1:0] prod_r [3][3][3];
  win_t sel;
  pix_t res;

  assign o_ready = !o_valid_r || out_tready;
  assign p_ready = !p_valid_r || o_ready;
  assign take    = q_valid && p_ready;
  assign is_a    = head.emit_a && !phase_r;
  assign last    = is_a ? !head.emit_b : 1'b1;
  assign q_pop   = take && last;
  assign phase_nxt = take ? (is_a && head.emit_b) : phase_r;

  // Window columns for the interior result or the end-of-row result.
  always_comb begin
    if (is_a) begin
      sel = head.win;
    end else begin
      sel[0] = head.win[1];
      sel[1] = head.win[2];
      sel[2] = head.win[2];
    end
  end

  // Sum, shift and clip of each channel.
  always_comb begin
    logic signed [SUM_BITS-1:0] sum, shifted;
    for (int ch = 0; ch < 3; ch++) begin
      sum = '0;
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          sum = sum + SUM_BITS'(prod_r[ch][y][x]);
        end
      end
      shifted = sum >>> cfg.shift;
      if (sum <= 0) begin
        res[ch*8 +: 8] = 8'd0;
      end else if (shifted > SUM_BITS'(255)) begin
        res[ch*8 +: 8] = 8'd255;
      end else begin
        res[ch*8 +: 8] = shifted[7:0];
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 1'b0;
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (p_ready) begin
        p_valid_r <= take;
      end
      if (o_ready) begin
        o_valid_r <= p_valid_r;
      end
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (take) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int y = 0; y < 3; y++) begin
          for (int x = 0; x < 3; x++) begin
            prod_r[ch][y][x] <= PROD_BITS'(coeff(cfg.kernel[y], x) *
                                 $signed({1'b0, sel[x][y][ch*8 +: 8]}));
          end
        end
      end
      p_eol_r  <= !is_a;
      p_eof_r  <= !is_a && head.drain;
      p_last_r <= last;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (o_ready && p_valid_r) begin
      out_pix  <= res;
      out_eol  <= p_eol_r;
      out_eof  <= p_eof_r;
      out_last <= p_last_r;
    end
  end

  assign out_tvalid = o_valid_r;

endmodule

>>> rtl/rgb_conv3x3_clamp_edge_core.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_clamp_edge_core: 3x3 RGB convolution with clamp-to-edge borders
//
//   Channel | Direction | Contents
//   in_     | slave     | tdata: red, green, blue; tuser: drain command
//   out_    | master    | tdata: red, green, blue; tlast: end of line;
//           |           | tuser: end of frame, end of run
//   cfg_    | write     | frame size, three kernel rows, result shift
//
// One request is taken every cycle while the queue has room; a request that
// closes a row can yield two results, formed one after the other, so the
// short queue absorbs it. A request passes the line buffer read, window,
// queue, products, and sum and clip. Reset clears the raster position and the
// pipeline; line buffers need no clearing. Either side may stall freely.
// ----------------------------------------------------------------------------
module rgb_conv3x3_clamp_edge_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in, green_in, blue_in
  input  logic [0:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red_out, green_out, blue_out
  output logic        out_tlast,  // end_of_line
  output logic [1:0]  out_tuser   // end_of_frame, run_end
);
  import rcc_pkg::*;

  logic [DIM_BITS-1:0]   width_r, height_r;
  logic [KROW_BITS-1:0]  ktop_r, kmid_r, kbot_r;
  logic [SHIFT_BITS-1:0] shift_r;
  cfg_t                  cfg;
  logic                  q_push, q_full, q_pop, q_valid;
  q_entry_t              q_data, q_head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_BITS'(640);
      height_r <= DIM_BITS'(480);
      ktop_r   <= KROW_BITS'(24'hFFFFFF);
      kmid_r   <= KROW_BITS'(24'hFF08FF);
      kbot_r   <= KROW_BITS'(24'hFFFFFF);
      shift_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:   width_r  <= cfg_wr_data[DIM_BITS-1:0];
        REG_FRAME_HEIGHT:  height_r <= cfg_wr_data[DIM_BITS-1:0];
        REG_KERNEL_TOP:    ktop_r   <= cfg_wr_data[KROW_BITS-1:0];
        REG_KERNEL_MIDDLE: kmid_r   <= cfg_wr_data[KROW_BITS-1:0];
        REG_KERNEL_BOTTOM: kbot_r   <= cfg_wr_data[KROW_BITS-1:0];
        REG_RESULT_SHIFT:  shift_r  <= cfg_wr_data[SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero counts as one, large values saturate.
  always_comb begin
    if (width_r == '0) begin
      cfg.width = DIM_BITS'(1);
    end else if (width_r > DIM_BITS'(MAX_WIDTH)) begin
      cfg.width = DIM_BITS'(MAX_WIDTH);
    end else begin
      cfg.width = width_r;
    end
    if (height_r == '0) begin
      cfg.height = DIM_BITS'(1);
    end else if (height_r > DIM_BITS'(MAX_HEIGHT)) begin
      cfg.height = DIM_BITS'(MAX_HEIGHT);
    end else begin
      cfg.height = height_r;
    end
    cfg.kernel[0] = ktop_r;
    cfg.kernel[1] = kmid_r;
    cfg.kernel[2] = kbot_r;
    cfg.shift     = shift_r;
  end

  rcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_drain  (in_tuser[0]),
    .in_pix    (in_tdata),
    .q_push    (q_push),
    .q_data    (q_data),
    .q_full    (q_full)
  );

  rcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  rcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .head       (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_pix    (out_tdata),
    .out_eol    (out_tlast),
    .out_eof    (out_tuser[0]),
    .out_last   (out_tuser[1])
  );

endmodule
